### hw/rtl/deq_pkg.sv
package deq_pkg;

    // Action codes carried in the item
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_REAR   = 3'd3;
    localparam logic [2:0] ACT_DUMP_FWD   = 3'd4;
    localparam logic [2:0] ACT_DUMP_BACK  = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Longest dump, in results
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] push_value;
    } t_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        ADDR_NEW_FRONT,
        ADDR_REAR,
        ADDR_FRONT,
        ADDR_BACK,
        ADDR_DUMP
    } t_addr_sel;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_PUSH_FRONT,
        PTR_PUSH_REAR,
        PTR_POP_FRONT,
        PTR_POP_REAR
    } t_ptr_op;

    typedef struct packed {
        logic      wr_en;
        logic      rd_en;
        t_addr_sel addr_sel;
        t_ptr_op   ptr_op;
        logic      dump_init;
        logic      dump_adv;
        logic      dump_dir;
        logic      emit;
        logic [1:0] emit_status;
        logic      emit_last;
        logic      emit_data;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic first_last;
        logic next_last;
    } t_dp_stat;

endpackage

### hw/rtl/deq_dpath.sv
module deq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_dp_cmd   i_cmd,
    input  logic signed [31:0] i_push_value,
    output deq_pkg::t_dp_stat  o_stat,
    output logic               o_valid,
    output deq_pkg::t_result   o_result
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int LIM = (DEPTH < deq_pkg::MAX_RESULTS) ? DEPTH : deq_pkg::MAX_RESULTS;

    localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [CW-1:0] LIM_C     = CW'(LIM);
    localparam logic [CW-1:0] ONE_C     = CW'(1);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;
    logic [AW-1:0]      r_front;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic               r_dir;
    logic               r_valid;
    logic [1:0]         r_status;
    logic               r_last;
    logic               r_data_en;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [CW-1:0] total;
    logic [CW-1:0] idx_cur;
    logic          dir_cur;
    logic [CW-1:0] dump_n;
    logic [CW-1:0] offset;
    logic [AW:0]   slot_sum;
    logic [AW:0]   slot_wrap;
    logic [AW-1:0] addr;

    always_comb begin
        front_dec = (r_front == '0) ? LAST_SLOT : r_front - AW'(1);
        front_inc = (r_front == LAST_SLOT) ? '0 : r_front + AW'(1);
        total     = (r_count > LIM_C) ? LIM_C : r_count;
        idx_cur   = i_cmd.dump_init ? '0 : r_idx;
        dir_cur   = i_cmd.dump_init ? i_cmd.dump_dir : r_dir;
        dump_n    = dir_cur ? (r_count - ONE_C - idx_cur) : idx_cur;

        case (i_cmd.addr_sel)
            deq_pkg::ADDR_REAR: begin
                offset = r_count;
            end
            deq_pkg::ADDR_BACK: begin
                offset = r_count - ONE_C;
            end
            deq_pkg::ADDR_DUMP: begin
                offset = dump_n;
            end
            default: begin
                offset = '0;
            end
        endcase

        // Both terms stay below DEPTH, so one subtract folds the ring
        slot_sum  = {1'b0, r_front} + (AW + 1)'(offset);
        slot_wrap = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;

        case (i_cmd.addr_sel)
            deq_pkg::ADDR_NEW_FRONT: begin
                addr = front_dec;
            end
            deq_pkg::ADDR_FRONT: begin
                addr = r_front;
            end
            default: begin
                addr = slot_wrap[AW-1:0];
            end
        endcase
    end

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == DEPTH_C);
    assign o_stat.first_last = (total == ONE_C);
    assign o_stat.next_last  = ((r_idx + ONE_C) == total);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[addr] <= i_push_value;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_dir   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            case (i_cmd.ptr_op)
                deq_pkg::PTR_PUSH_FRONT: begin
                    r_front <= front_dec;
                    r_count <= r_count + ONE_C;
                end
                deq_pkg::PTR_PUSH_REAR: begin
                    r_count <= r_count + ONE_C;
                end
                deq_pkg::PTR_POP_FRONT: begin
                    r_front <= front_inc;
                    r_count <= r_count - ONE_C;
                end
                deq_pkg::PTR_POP_REAR: begin
                    r_count <= r_count - ONE_C;
                end
                default: begin
                end
            endcase
            if (i_cmd.dump_init) begin
                r_idx <= ONE_C;
                r_dir <= i_cmd.dump_dir;
            end else if (i_cmd.dump_adv) begin
                r_idx <= r_idx + ONE_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status  <= i_cmd.emit_status;
            r_last    <= i_cmd.emit_last;
            r_data_en <= i_cmd.emit_data;
        end
    end

    assign o_valid         = r_valid;
    assign o_result.value  = r_data_en ? r_rdata : '0;
    assign o_result.status = r_status;
    assign o_result.last   = r_last;

endmodule

### hw/rtl/deq_ctrl.sv
module deq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_action,
    input  deq_pkg::t_dp_stat i_stat,
    output deq_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.emit_status = deq_pkg::ST_FULL;
                            end else begin
                                o_cmd.emit_status = deq_pkg::ST_OK;
                                o_cmd.wr_en       = 1'b1;
                                if (i_action == deq_pkg::ACT_PUSH_FRONT) begin
                                    o_cmd.addr_sel = deq_pkg::ADDR_NEW_FRONT;
                                    o_cmd.ptr_op   = deq_pkg::PTR_PUSH_FRONT;
                                end else begin
                                    o_cmd.addr_sel = deq_pkg::ADDR_REAR;
                                    o_cmd.ptr_op   = deq_pkg::PTR_PUSH_REAR;
                                end
                            end
                        end
                        deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_REAR: begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_last = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.emit_status = deq_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.emit_status = deq_pkg::ST_OK;
                                o_cmd.emit_data   = 1'b1;
                                o_cmd.rd_en       = 1'b1;
                                if (i_action == deq_pkg::ACT_POP_FRONT) begin
                                    o_cmd.addr_sel = deq_pkg::ADDR_FRONT;
                                    o_cmd.ptr_op   = deq_pkg::PTR_POP_FRONT;
                                end else begin
                                    o_cmd.addr_sel = deq_pkg::ADDR_BACK;
                                    o_cmd.ptr_op   = deq_pkg::PTR_POP_REAR;
                                end
                            end
                        end
                        deq_pkg::ACT_DUMP_FWD, deq_pkg::ACT_DUMP_BACK: begin
                            o_cmd.emit = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.emit_status = deq_pkg::ST_EMPTY;
                                o_cmd.emit_last   = 1'b1;
                            end else begin
                                // Read the first entry right away
                                o_cmd.emit_status = deq_pkg::ST_OK;
                                o_cmd.emit_data   = 1'b1;
                                o_cmd.emit_last   = i_stat.first_last;
                                o_cmd.rd_en       = 1'b1;
                                o_cmd.addr_sel    = deq_pkg::ADDR_DUMP;
                                o_cmd.dump_init   = 1'b1;
                                o_cmd.dump_dir    = (i_action == deq_pkg::ACT_DUMP_BACK);
                                if (!i_stat.first_last) begin
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_status = deq_pkg::ST_OK;
                o_cmd.emit_data   = 1'b1;
                o_cmd.emit_last   = i_stat.next_last;
                o_cmd.rd_en       = 1'b1;
                o_cmd.addr_sel    = deq_pkg::ADDR_DUMP;
                o_cmd.dump_adv    = 1'b1;
                if (i_stat.next_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == S_DUMP);

endmodule

### hw/rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words held in a DEPTH-entry
// ring buffer. Raise start with an item while busy is low; the item is taken
// at that clock edge. Every result shows on o_result for exactly one cycle
// with o_valid high, starting the cycle after the item is taken, and the
// receiver must take it then: there is no way to hold results off. Push and
// pop items give one result each and never raise busy, so a new item may
// follow in every cycle. A dump of N stored entries gives min(N, 16)
// results on consecutive cycles, one memory read per entry through the
// single port of the entry store, with busy high for all but the last of
// those cycles; the final result carries last. A push to a full queue, or a
// pop or dump of an empty one, gives one status result and changes nothing.
// Action codes 6 and 7 are dropped without a result. The entry store needs
// no clearing after reset, as only occupied slots are ever read.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  deq_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_valid,
    output deq_pkg::t_result o_result
);

    deq_pkg::t_dp_cmd  cmd;
    deq_pkg::t_dp_stat stat;

    // Sequence each item: decode the action, check full/empty, step dumps
    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the ring pointers, the entry store and the result register
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_value (i_item.push_value),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_result     (o_result)
    );

    // While a dump runs, the result just shown is a dump entry that is not last
    a_busy_mid_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_valid && !o_result.last && o_result.status == deq_pkg::ST_OK))
        else $error("busy without a pending dump result");

    // Every item with a defined action gives a result in the next cycle
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action <= deq_pkg::ACT_DUMP_BACK) |=> o_valid)
        else $error("accepted item produced no result");

    // A result only follows an accepted item or a running dump
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result without a cause");

    // Error results are single, final and carry a zero word
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != deq_pkg::ST_OK)
            |-> (o_result.last && o_result.value == '0 && !busy))
        else $error("malformed error result");

endmodule

### sim/tb_double_ended_queue.sv
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 370;
    localparam int CALM_TAIL    = 60;
    localparam int SETTLE       = 40;

    // Codes the block drops without a result
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Shadow copy of the deque: ring of words, front slot and fill level
    logic signed [31:0] ring [DEPTH];
    int                 front_slot;
    int                 fill;

    // Results the block still owes, oldest first
    t_result deque_replies [$];
    int      error_count;

    // One row of the directed script; typed rows carry the single result
    // that can be read off directly, the rest go through the shadow deque
    typedef struct {
        logic [2:0]  action;
        logic [31:0] word;
        int          reps;
        bit          typed;
        logic [31:0] want_value;
        logic [1:0]  want_status;
    } t_row;

    localparam int ROWS = 25;
    t_row script [ROWS] = '{
        // empty deque right after reset
        '{ACT_POP_FRONT,  32'h0,         1,  1'b1, 32'h0,         ST_EMPTY},
        '{ACT_POP_REAR,   32'h0,         1,  1'b1, 32'h0,         ST_EMPTY},
        '{ACT_DUMP_FWD,   32'h0,         1,  1'b1, 32'h0,         ST_EMPTY},
        '{ACT_DUMP_BACK,  32'h0,         1,  1'b1, 32'h0,         ST_EMPTY},
        // single entry, extreme words, both ends
        '{ACT_PUSH_FRONT, 32'h8000_0000, 1,  1'b1, 32'h0,         ST_OK},
        '{ACT_POP_REAR,   32'h0,         1,  1'b1, 32'h8000_0000, ST_OK},
        '{ACT_PUSH_REAR,  32'h7fff_ffff, 1,  1'b1, 32'h0,         ST_OK},
        '{ACT_POP_FRONT,  32'h0,         1,  1'b1, 32'h7fff_ffff, ST_OK},
        // spare codes: no result expected
        '{ACT_SPARE_6,    32'hffff_ffff, 1,  1'b0, 32'h0,         ST_OK},
        '{ACT_SPARE_7,    32'h1234_5678, 1,  1'b0, 32'h0,         ST_OK},
        // dump of a single entry, both directions
        '{ACT_PUSH_REAR,  32'hffff_ffff, 1,  1'b1, 32'h0,         ST_OK},
        '{ACT_DUMP_FWD,   32'h0,         1,  1'b1, 32'hffff_ffff, ST_OK},
        '{ACT_DUMP_BACK,  32'h0,         1,  1'b1, 32'hffff_ffff, ST_OK},
        // fill to the brim through the front, then overfill from both ends
        '{ACT_PUSH_FRONT, 32'h0000_0100, 15, 1'b1, 32'h0,         ST_OK},
        '{ACT_PUSH_FRONT, 32'h0000_0001, 1,  1'b1, 32'h0,         ST_FULL},
        '{ACT_PUSH_REAR,  32'h0000_0001, 1,  1'b1, 32'h0,         ST_FULL},
        '{ACT_DUMP_FWD,   32'h0,         1,  1'b0, 32'h0,         ST_OK},
        '{ACT_DUMP_BACK,  32'h0,         1,  1'b0, 32'h0,         ST_OK},
        // drain from both ends across the wrap point
        '{ACT_POP_FRONT,  32'h0,         8,  1'b0, 32'h0,         ST_OK},
        '{ACT_POP_REAR,   32'h0,         8,  1'b0, 32'h0,         ST_OK},
        '{ACT_POP_REAR,   32'h0,         1,  1'b1, 32'h0,         ST_EMPTY},
        // mixed ends, then dumps
        '{ACT_PUSH_REAR,  32'h5555_5555, 3,  1'b0, 32'h0,         ST_OK},
        '{ACT_PUSH_FRONT, 32'haaaa_aaaa, 3,  1'b0, 32'h0,         ST_OK},
        '{ACT_DUMP_FWD,   32'h0,         1,  1'b0, 32'h0,         ST_OK},
        '{ACT_DUMP_BACK,  32'h0,         1,  1'b0, 32'h0,         ST_OK}
    };

    function automatic t_result make_result(logic [31:0] value, logic [1:0] status,
                                            logic last);
        t_result r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t: %s got %h, want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Apply one accepted item to the shadow deque and queue up what it owes
    task automatic run_action(input t_item it, input bit typed, input t_result want);
        t_result owed [$];
        logic signed [31:0] word;
        int total;
        int n;
        case (it.action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (fill >= DEPTH) begin
                    owed.push_back(make_result(32'h0, ST_FULL, 1'b1));
                end else begin
                    if (it.action == ACT_PUSH_FRONT) begin
                        front_slot = (front_slot + DEPTH - 1) % DEPTH;
                        ring[front_slot] = it.push_value;
                    end else begin
                        ring[(front_slot + fill) % DEPTH] = it.push_value;
                    end
                    fill++;
                    owed.push_back(make_result(32'h0, ST_OK, 1'b1));
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
                if (fill == 0) begin
                    owed.push_back(make_result(32'h0, ST_EMPTY, 1'b1));
                end else begin
                    if (it.action == ACT_POP_FRONT) begin
                        word = ring[front_slot];
                        front_slot = (front_slot + 1) % DEPTH;
                    end else begin
                        word = ring[(front_slot + fill - 1) % DEPTH];
                    end
                    fill--;
                    owed.push_back(make_result(word, ST_OK, 1'b1));
                end
            end
            ACT_DUMP_FWD, ACT_DUMP_BACK: begin
                if (fill == 0) begin
                    owed.push_back(make_result(32'h0, ST_EMPTY, 1'b1));
                end else begin
                    total = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
                    for (int i = 0; i < total; i++) begin
                        n = (it.action == ACT_DUMP_FWD) ? i : fill - 1 - i;
                        owed.push_back(make_result(ring[(front_slot + n) % DEPTH], ST_OK,
                                                   i == total - 1));
                    end
                end
            end
            default: begin
                // spare codes: drop silently
            end
        endcase
        if (typed) begin
            deque_replies.push_back(want);
        end else begin
            foreach (owed[k]) deque_replies.push_back(owed[k]);
        end
    endtask

    // Present one item from the falling edge and hold it until the block takes it
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        run_action(it, typed, want);
    endtask

    // Drop start for a burst of cycles, with junk on the item bus
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start  <= 1'b0;
            i_item <= {3'($urandom()), 32'($urandom())};
        end
    endtask

    // Hold off new items until the block owes nothing
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (deque_replies.size() != 0) @(negedge i_clk);
    endtask

    // Compare each result with the oldest one owed
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (deque_replies.size() == 0) begin
                report_mismatch("unexpected result", o_result.value, 32'h0);
            end else begin
                want = deque_replies.pop_front();
                if (o_result.value !== want.value)
                    report_mismatch("value", o_result.value, want.value);
                if (o_result.status !== want.status)
                    report_mismatch("status", 32'(o_result.status), 32'(want.status));
                if (o_result.last !== want.last)
                    report_mismatch("last", 32'(o_result.last), 32'(want.last));
            end
        end
    end

    initial begin
        t_item   it;
        t_result want;
        int      sent;
        int      pick;
        int      push_share;
        int      waited;

        error_count = 0;
        front_slot  = 0;
        fill        = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed script
        foreach (script[r]) begin
            for (int k = 0; k < script[r].reps; k++) begin
                it.action     = script[r].action;
                it.push_value = script[r].word + k;
                want = make_result(script[r].want_value, script[r].want_status, 1'b1);
                send_item(it, script[r].typed, want);
            end
        end
        wait_drained();

        // Random part: windows lean toward pushes or pops so the fill level
        // swings between empty and full
        sent       = 0;
        push_share = 40;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_share = 65;
                    1:       push_share = 20;
                    default: push_share = 40;
                endcase
            end
            // Sender gaps everywhere but in the calm tail
            if (sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 4) == 0)
                idle_cycles($urandom_range(1, 7));
            if (sent == 150 || (sent % 50 == 25 && $urandom_range(0, 3) == 0))
                wait_drained();

            pick = $urandom_range(0, 99);
            if (pick < 3)
                it.action = $urandom_range(0, 1) ? ACT_SPARE_7 : ACT_SPARE_6;
            else if (pick < 15)
                it.action = $urandom_range(0, 1) ? ACT_DUMP_BACK : ACT_DUMP_FWD;
            else if (pick < 15 + push_share)
                it.action = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
            else
                it.action = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;

            case ($urandom_range(0, 9))
                0:       it.push_value = 32'h8000_0000;
                1:       it.push_value = 32'h7fff_ffff;
                2:       it.push_value = 32'hffff_ffff;
                3:       it.push_value = 32'h0;
                default: it.push_value = $urandom();
            endcase

            send_item(it, 1'b0, want);
            if (it.action != ACT_SPARE_6 && it.action != ACT_SPARE_7)
                sent++;
        end

        // Let every owed result arrive, then watch for strays
        @(negedge i_clk);
        start  <= 1'b0;
        waited = 0;
        while (deque_replies.size() != 0 && waited < 10000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (deque_replies.size() != 0)
            report_mismatch("results never arrived", deque_replies.size(), 32'h0);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_dpath.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue.sv
sim/tb_double_ended_queue.sv
